[src/acv_pkg.sv]
// Shared types and constants for the AVCC to Annex B converter.
// No dependencies; used by the parser, the emitter and the top level.
package acv_pkg;

   localparam logic [7:0] KEY_FRAME_BYTE  = 8'h17;
   localparam logic [7:0] PKT_SEQ_HEADER  = 8'h00;
   localparam logic [7:0] PKT_NALU        = 8'h01;
   localparam logic [7:0] START_CODE_LAST = 8'h01;
   localparam logic [7:0] START_CODE_ZERO = 8'h00;
   localparam logic [2:0] START_CODE_LEN  = 3'd4;
   localparam logic [3:0] NALU_LEN_BYTES  = 4'd4;
   localparam logic [3:0] PS_LEN_BYTES    = 4'd2;
   localparam logic [3:0] NALU_HDR_END    = 4'd4;
   localparam logic [3:0] SEQ_HDR_END     = 4'd9;
   localparam logic [3:0] SKIP_START      = 4'd2;

   // results of one input byte: optional start code, optional payload byte,
   // optional truncation marker; pe marks the last start-code/payload byte
   typedef struct packed {
      logic       sc;
      logic       dv;
      logic [7:0] data;
      logic       pe;
      logic       tr;
   } burst_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } emit_status_type;

endpackage

[src/avcc_to_annexb_converter.sv]
// AVCC to Annex B converter for FLV video tag bodies, top level.
// Each accepted byte's descriptor is registered in the emitter, then stepped into the rsp_ output register.
// Throughput: 1 byte per cycle while each byte yields at most one result and rsp_stall is low;
// a byte that yields more than one result holds req_stall while the emitter drains it.
// Reset: synchronous, active high; clears parse state and the key-frame flag.
// Depends on acv_pkg, acv_parse and acv_emit.
module avcc_to_annexb_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte,
   output logic       rsp_packet_end,
   output logic       rsp_truncated,
   output logic       rsp_run_last
);

   acv_pkg::burst_type       burst;
   acv_pkg::emit_status_type status;
   logic                     accept;
   logic                     load;

   assign req_stall = status.busy && !status.finishing;
   assign accept    = req_valid && !req_stall;
   assign load      = accept && (burst.sc || burst.dv || burst.tr);

   acv_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_byte (req_byte),
      .req_last (req_last),
      .burst    (burst)
   );

   acv_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .burst          (burst),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte       (rsp_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_truncated  (rsp_truncated),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

[src/acv_parse.sv]
// Tag parser: per-byte state update and result descriptor.
// Depends on acv_pkg.
module acv_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         req_byte,
   input  logic               req_last,
   output acv_pkg::burst_type burst
);

   typedef enum logic [3:0] {
      PH_FIRST, PH_TYPE, PH_SKIP, PH_SPSCNT, PH_LEN, PH_DATA, PH_PPSCNT, PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SPS, KIND_NALU, KIND_OTHER, KIND_PPS
   } kind_type;

   logic        started_ff, started_in;
   logic        enabled_ff, enabled_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  hidx_ff, hidx_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] left_ff, left_in;
   logic [4:0]  sets_ff, sets_in;
   kind_type    kind_ff, kind_in;

   always_comb begin
      logic       unit_done;
      logic       group;
      logic [3:0] width;
      started_in = started_ff;
      enabled_in = enabled_ff;
      phase_in   = phase_ff;
      hidx_in    = hidx_ff;
      accum_in   = accum_ff;
      left_in    = left_ff;
      sets_in    = sets_ff;
      kind_in    = kind_ff;
      burst      = '0;
      unit_done  = 1'b0;
      group      = 1'b0;
      width      = (kind_ff == KIND_NALU) ? acv_pkg::NALU_LEN_BYTES : acv_pkg::PS_LEN_BYTES;
      case (phase_ff)
         PH_FIRST: begin
            if (req_byte == acv_pkg::KEY_FRAME_BYTE) started_in = 1'b1;
            enabled_in = started_in;
            phase_in   = started_in ? PH_TYPE : PH_IDLE;
            hidx_in    = '0;
         end
         PH_TYPE: begin
            if (req_byte == acv_pkg::PKT_SEQ_HEADER || req_byte == acv_pkg::PKT_NALU) begin
               kind_in  = (req_byte == acv_pkg::PKT_NALU) ? KIND_NALU : KIND_SPS;
               phase_in = PH_SKIP;
               hidx_in  = acv_pkg::SKIP_START;
            end else begin
               kind_in  = KIND_OTHER;
               phase_in = PH_IDLE;
            end
         end
         PH_SKIP: begin
            if (kind_ff == KIND_NALU && hidx_ff >= acv_pkg::NALU_HDR_END) begin
               phase_in = PH_LEN;
               hidx_in  = '0;
               accum_in = '0;
            end else if (kind_ff != KIND_NALU && hidx_ff >= acv_pkg::SEQ_HDR_END) begin
               phase_in = PH_SPSCNT;
            end else begin
               hidx_in = hidx_ff + 4'd1;
            end
         end
         PH_SPSCNT, PH_PPSCNT: begin
            sets_in = req_byte[4:0];
            group   = 1'b1;
         end
         PH_LEN: begin
            accum_in = {accum_ff[23:0], req_byte};
            hidx_in  = hidx_ff + 4'd1;
            if (hidx_in >= width) begin
               burst.sc = 1'b1;
               left_in  = accum_in;
               if (accum_in == '0) unit_done = 1'b1;
               else phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            burst.dv   = 1'b1;
            burst.data = req_byte;
            left_in    = left_ff - 32'd1;
            if (left_in == '0) unit_done = 1'b1;
         end
         default: begin
         end
      endcase

      if (unit_done) begin
         if (kind_in == KIND_NALU) begin
            phase_in = PH_LEN;
            hidx_in  = '0;
            accum_in = '0;
         end else begin
            sets_in = sets_in - 5'd1;
            if (sets_in == '0) begin
               burst.pe = 1'b1;
               group    = 1'b1;
            end else begin
               phase_in = PH_LEN;
               hidx_in  = '0;
               accum_in = '0;
            end
         end
      end

      if (group) begin
         if (sets_in == '0) begin
            if (kind_in == KIND_SPS) begin
               kind_in  = KIND_PPS;
               phase_in = PH_PPSCNT;
            end else begin
               phase_in = PH_IDLE;
            end
         end else begin
            phase_in = PH_LEN;
            hidx_in  = '0;
            accum_in = '0;
         end
      end

      if (req_last) begin
         if (enabled_in && phase_in != PH_TYPE && phase_in != PH_FIRST) begin
            if (kind_in == KIND_NALU) begin
               if (phase_in == PH_DATA || (phase_in == PH_LEN && hidx_in != '0))
                  burst.tr = 1'b1;
               else
                  burst.pe = 1'b1;
            end else if (kind_in != KIND_OTHER && phase_in != PH_IDLE) begin
               burst.tr = 1'b1;
            end
         end
         phase_in   = PH_FIRST;
         enabled_in = 1'b0;
         hidx_in    = '0;
         accum_in   = '0;
         left_in    = '0;
         sets_in    = '0;
         kind_in    = KIND_SPS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         enabled_ff <= 1'b0;
         phase_ff   <= PH_FIRST;
         hidx_ff    <= '0;
         accum_ff   <= '0;
         left_ff    <= '0;
         sets_ff    <= '0;
         kind_ff    <= KIND_SPS;
      end else if (accept) begin
         started_ff <= started_in;
         enabled_ff <= enabled_in;
         phase_ff   <= phase_in;
         hidx_ff    <= hidx_in;
         accum_ff   <= accum_in;
         left_ff    <= left_in;
         sets_ff    <= sets_in;
         kind_ff    <= kind_in;
      end
   end

endmodule

[src/acv_emit.sv]
// Result emitter: holds one byte's descriptor and steps it into the output register.
// Depends on acv_pkg.
module acv_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  acv_pkg::burst_type       burst,
   output acv_pkg::emit_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_byte,
   output logic                     rsp_packet_end,
   output logic                     rsp_truncated,
   output logic                     rsp_run_last
);

   acv_pkg::burst_type desc_ff;
   logic [2:0]         idx_ff;
   logic               busy_ff;
   logic               valid_ff;
   logic [7:0]         byte_ff, byte_in;
   logic               pe_ff, pe_in;
   logic               tr_ff, tr_in;
   logic               last_ff, last_in;
   logic [2:0]         body;
   logic [2:0]         total;
   logic               advance;
   logic               finish;

   assign body    = desc_ff.sc ? acv_pkg::START_CODE_LEN : {2'b00, desc_ff.dv};
   assign total   = body + {2'b00, desc_ff.tr};
   assign advance = busy_ff && (!valid_ff || !rsp_stall);
   assign finish  = advance && (idx_ff == total - 3'd1);

   always_comb begin
      last_in = (idx_ff == total - 3'd1);
      if (idx_ff < body) begin
         if (desc_ff.sc)
            byte_in = (idx_ff == acv_pkg::START_CODE_LEN - 3'd1) ?
                      acv_pkg::START_CODE_LAST : acv_pkg::START_CODE_ZERO;
         else
            byte_in = desc_ff.data;
         pe_in = desc_ff.pe && (idx_ff == body - 3'd1);
         tr_in = 1'b0;
      end else begin
         byte_in = '0;
         pe_in   = 1'b1;
         tr_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end else if (advance) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (advance) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
      if (load) desc_ff <= burst;
      if (advance) begin
         byte_ff <= byte_in;
         pe_ff   <= pe_in;
         tr_ff   <= tr_in;
         last_ff <= last_in;
      end
   end

   assign status.busy      = busy_ff;
   assign status.finishing = finish;
   assign rsp_valid        = valid_ff;
   assign rsp_byte         = byte_ff;
   assign rsp_packet_end   = pe_ff;
   assign rsp_truncated    = tr_ff;
   assign rsp_run_last     = last_ff;

endmodule

[src/acv_checker.sv]
// Port-level checks for the AVCC to Annex B converter, bound to the top level.
// Depends only on the top level's ports.
module acv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_byte,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_byte,
   input logic       rsp_packet_end,
   input logic       rsp_truncated,
   input logic       rsp_run_last
);

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_packet_end && rsp_byte == 8'h00)
      else $error("truncation marker without packet end or with nonzero byte");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_run_last)
      else $error("truncation marker is not the final result of its byte");

   a_burst_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last && rsp_stall |-> req_stall)
      else $error("input taken while a stalled burst still has results pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_run_last))
      else $error("stalled result transaction changed");

endmodule

bind avcc_to_annexb_converter acv_checker u_acv_checker (.*);
